[rtl/flr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log placement package
// Widths, codes and shared types of the circular log record placement block.
// ----------------------------------------------------------------------------
package flr_pkg;

   // Geometry limits of the log area.
   localparam int MAX_BLOCKS      = 256;
   localparam int MAX_CHUNKS_LOG2 = 10;

   // Field and state widths.
   localparam int CMD_W     = 2;
   localparam int VER_W     = 32;
   localparam int ACT_W     = 3;
   localparam int CHUNK_W   = 18;
   localparam int POS_W     = CHUNK_W + 1;
   localparam int BLOCK_W   = 8;
   localparam int TALLY_W   = 9;
   localparam int TRIES_W   = TALLY_W + 1;
   localparam int LOG2_W    = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 9;

   // Register values after reset.
   localparam int RESET_BLOCKS = 256;
   localparam int RESET_LOG2   = 7;
   localparam logic [CHUNK_W-1:0] RESET_OFFSET =
      CHUNK_W'((RESET_BLOCKS << RESET_LOG2) - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_LOG2  = 1'b1;

   // Command codes of an input item.
   localparam logic [CMD_W-1:0] CMD_SCAN    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OUTCOME = 2'd2;

   // Result queue depth, in input items.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_READ        = 3'd0,
      ACT_ERASE       = 3'd1,
      ACT_WRITE       = 3'd2,
      ACT_ERASE_PREV  = 3'd3,
      ACT_COMMIT_OK   = 3'd4,
      ACT_COMMIT_FAIL = 3'd5,
      ACT_SCAN_DONE   = 3'd6,
      ACT_REJECT      = 3'd7
   } action_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             op_ok;
      logic [VER_W-1:0] found_version;
      logic             chunk_blank;
   } req_item_type;

   // Results of one input item: an optional erase of the previous block
   // ahead of the main result.
   typedef struct packed {
      logic               pre_valid;
      logic [CHUNK_W-1:0] pre_chunk;
      logic [BLOCK_W-1:0] pre_block;
      action_type         action;
      logic [CHUNK_W-1:0] chunk;
      logic [BLOCK_W-1:0] block;
      logic [VER_W-1:0]   version;
      logic [TALLY_W-1:0] tally;
      logic               last;
   } rsp_entry_type;

endpackage

[rtl/flr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one command item toward the block.
// ----------------------------------------------------------------------------
interface flr_req_if;

   logic                      valid;
   logic                      ready;
   logic [flr_pkg::CMD_W-1:0] cmd;
   logic                      op_ok;
   logic [flr_pkg::VER_W-1:0] found_version;
   logic                      chunk_blank;

   modport source (output valid, cmd, op_ok, found_version, chunk_blank,
                   input ready);
   modport sink (input valid, cmd, op_ok, found_version, chunk_blank,
                 output ready);

endinterface

[rtl/flr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item out of the block.
// ----------------------------------------------------------------------------
interface flr_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [flr_pkg::ACT_W-1:0]   action;
   logic [flr_pkg::CHUNK_W-1:0] chunk_index;
   logic [flr_pkg::BLOCK_W-1:0] block_index;
   logic [flr_pkg::VER_W-1:0]   record_version;
   logic [flr_pkg::TALLY_W-1:0] blocks_counted;
   logic                        last;

   modport source (output valid, action, chunk_index, block_index,
                   record_version, blocks_counted, last,
                   input ready);
   modport sink (input valid, action, chunk_index, block_index,
                 record_version, blocks_counted, last,
                 output ready);

endinterface

[rtl/flr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log placement core
// Configuration registers, placement state and the combinational step logic
// that turns one command item into its results.
// ----------------------------------------------------------------------------
module flr_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [flr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [flr_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  logic                               item_valid,
   input  flr_pkg::req_item_type              item,
   output flr_pkg::rsp_entry_type             entry_o
);
   import flr_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SCAN  = 4'b0010,
      PH_ERASE = 4'b0100,
      PH_WRITE = 4'b1000
   } phase_type;

   // Configuration registers.
   logic [TALLY_W-1:0] block_count_ff;
   logic [LOG2_W-1:0]  chunk_log2_ff;

   // Placement state.
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [CHUNK_W-1:0] offset_ff, offset_in;
   logic [VER_W-1:0]   version_ff, version_in;
   logic [VER_W-1:0]   backup_ff, backup_in;
   logic [TRIES_W-1:0] tries_ff, tries_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;

   // Geometry in effect.
   logic [LOG2_W-1:0]  geo_log2;
   logic [TALLY_W-1:0] geo_blocks;
   logic [POS_W-1:0]   geo_total;
   logic [POS_W-1:0]   geo_cpb;
   logic [POS_W-1:0]   geo_mask;

   // Step working signals.
   logic               reject;
   logic               do_try;
   logic [POS_W-1:0]   try_pos;
   logic [POS_W-1:0]   try_wrap;
   logic [TRIES_W-1:0] try_tries;
   logic [VER_W-1:0]   try_backup;
   logic [POS_W-1:0]   step;
   logic [POS_W-1:0]   pos_boundary;

   // Out-of-range register values are clamped into the supported geometry.
   always_comb begin
      geo_log2 = (chunk_log2_ff > LOG2_W'(MAX_CHUNKS_LOG2)) ?
                 LOG2_W'(MAX_CHUNKS_LOG2) : chunk_log2_ff;
      if (block_count_ff == '0) begin
         geo_blocks = TALLY_W'(1);
      end else if (block_count_ff > TALLY_W'(MAX_BLOCKS)) begin
         geo_blocks = TALLY_W'(MAX_BLOCKS);
      end else begin
         geo_blocks = block_count_ff;
      end
   end

   assign geo_total    = POS_W'(geo_blocks) << geo_log2;
   assign geo_cpb      = POS_W'(1) << geo_log2;
   assign geo_mask     = geo_cpb - POS_W'(1);
   assign pos_boundary = (position_ff + geo_cpb) & ~geo_mask;

   // Unknown commands and commands that do not fit the current phase are turned away.
   assign reject = (item.cmd != CMD_SCAN && item.cmd != CMD_COMMIT &&
                    item.cmd != CMD_OUTCOME) ||
                   (item.cmd == CMD_OUTCOME && phase_ff == PH_IDLE) ||
                   (item.cmd != CMD_OUTCOME && phase_ff != PH_IDLE);

   // Step logic: next state and the results of one item.
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      offset_in   = offset_ff;
      version_in  = version_ff;
      backup_in   = backup_ff;
      tries_in    = tries_ff;
      tally_in    = tally_ff;

      do_try     = 1'b0;
      try_pos    = position_ff;
      try_tries  = tries_ff;
      try_backup = backup_ff;
      try_wrap   = position_ff;
      step       = position_ff + POS_W'(1);

      entry_o           = '0;
      entry_o.action    = ACT_REJECT;
      entry_o.chunk     = offset_ff;
      entry_o.last      = 1'b1;

      if (!reject) begin
         case (item.cmd)
            CMD_SCAN: begin
               version_in     = '0;
               offset_in      = CHUNK_W'(geo_total - POS_W'(1));
               position_in    = '0;
               tally_in       = TALLY_W'(1);
               phase_in       = PH_SCAN;
               entry_o.action = ACT_READ;
               entry_o.chunk  = '0;
               entry_o.last   = 1'b0;
            end
            CMD_COMMIT: begin
               backup_in  = version_ff;
               version_in = version_ff + VER_W'(1);
               do_try     = 1'b1;
               try_pos    = POS_W'(offset_ff) + POS_W'(1);
               try_tries  = {geo_blocks, 1'b0};
               try_backup = version_ff;
            end
            default: begin
               case (phase_ff)
                  PH_SCAN: begin
                     if (item.op_ok) begin
                        if (item.found_version > version_ff) begin
                           version_in = item.found_version;
                           offset_in  = position_ff[CHUNK_W-1:0];
                        end
                        if (item.found_version == '0 && item.chunk_blank) begin
                           step = pos_boundary;
                        end
                     end
                     position_in = step;
                     if (step >= geo_total) begin
                        phase_in       = PH_IDLE;
                        entry_o.action = ACT_SCAN_DONE;
                        entry_o.chunk  = offset_in;
                     end else begin
                        // Entering a new erase block counts it.
                        if ((step & geo_mask) == '0) begin
                           tally_in = tally_ff + TALLY_W'(1);
                        end
                        entry_o.action = ACT_READ;
                        entry_o.chunk  = step[CHUNK_W-1:0];
                        entry_o.last   = 1'b0;
                     end
                  end
                  PH_ERASE: begin
                     if (item.op_ok) begin
                        phase_in       = PH_WRITE;
                        entry_o.action = ACT_WRITE;
                        entry_o.chunk  = position_ff[CHUNK_W-1:0];
                        entry_o.last   = 1'b0;
                     end else begin
                        do_try  = 1'b1;
                        try_pos = position_ff + geo_cpb;
                     end
                  end
                  PH_WRITE: begin
                     if (item.op_ok) begin
                        // A record that moved into a fresh block frees the old one.
                        entry_o.pre_valid = ((position_ff & geo_mask) == '0) &&
                           ((position_ff >> geo_log2) !=
                            (POS_W'(offset_ff) >> geo_log2));
                        entry_o.pre_chunk = offset_ff & ~geo_mask[CHUNK_W-1:0];
                        offset_in         = position_ff[CHUNK_W-1:0];
                        phase_in          = PH_IDLE;
                        entry_o.action    = ACT_COMMIT_OK;
                        entry_o.chunk     = position_ff[CHUNK_W-1:0];
                     end else begin
                        do_try  = 1'b1;
                        try_pos = pos_boundary;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end

      // One commit attempt: give up when out of tries, else issue the next request.
      if (do_try) begin
         if (try_tries == '0) begin
            version_in     = try_backup;
            phase_in       = PH_IDLE;
            entry_o.action = ACT_COMMIT_FAIL;
            entry_o.chunk  = offset_ff;
            entry_o.last   = 1'b1;
         end else begin
            tries_in      = try_tries - TRIES_W'(1);
            try_wrap      = (try_pos >= geo_total) ? '0 : try_pos;
            position_in   = try_wrap;
            entry_o.chunk = try_wrap[CHUNK_W-1:0];
            entry_o.last  = 1'b0;
            if ((try_wrap & geo_mask) == '0) begin
               phase_in       = PH_ERASE;
               entry_o.action = ACT_ERASE;
            end else begin
               phase_in       = PH_WRITE;
               entry_o.action = ACT_WRITE;
            end
         end
      end

      entry_o.version   = version_in;
      entry_o.tally     = tally_in;
      entry_o.block     = BLOCK_W'(entry_o.chunk >> geo_log2);
      entry_o.pre_block = BLOCK_W'(entry_o.pre_chunk >> geo_log2);
   end

   // Configuration registers take effect at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= TALLY_W'(RESET_BLOCKS);
         chunk_log2_ff  <= LOG2_W'(RESET_LOG2);
      end else if (csr_we) begin
         case (csr_index)
            REG_BLOCK_COUNT: block_count_ff <= csr_wdata;
            REG_CHUNK_LOG2:  chunk_log2_ff  <= csr_wdata[LOG2_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Placement state moves only when an item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         position_ff <= '0;
         offset_ff   <= RESET_OFFSET;
         version_ff  <= '0;
         backup_ff   <= '0;
         tries_ff    <= '0;
         tally_ff    <= '0;
      end else if (item_valid) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         offset_ff   <= offset_in;
         version_ff  <= version_in;
         backup_ff   <= backup_in;
         tries_ff    <= tries_in;
         tally_ff    <= tally_in;
      end
   end

   // A turned-away command leaves the placement state alone.
   assert property (@(posedge clock) disable iff (reset)
      item_valid && reject |=>
         $stable(phase_ff) && $stable(offset_ff) && $stable(version_ff))
      else $error("rejected item changed the placement state");

   // A failed commit restores the version held before it.
   assert property (@(posedge clock) disable iff (reset)
      item_valid && entry_o.action == ACT_COMMIT_FAIL |=> version_ff == backup_ff)
      else $error("commit failure did not restore the version");

   // A run that ends normally leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      item_valid && entry_o.last && !reject |=> phase_ff == PH_IDLE)
      else $error("block not idle after the final result of a run");

endmodule

[rtl/flr_rsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue of per-item results; an entry with an erase of the
// previous block is sent as two result items.
// ----------------------------------------------------------------------------
module flr_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  flr_pkg::rsp_entry_type push_entry,
   output logic                   can_push,
   flr_rsp_if.source              rsp_ch
);
   import flr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_entry_type    mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sub_ff, sub_in;

   rsp_entry_type    head;
   logic             show_pre;
   logic             rsp_hs;
   logic             pop_entry;

   assign head      = mem_ff[rd_ptr_ff];
   assign show_pre  = head.pre_valid && !sub_ff;
   assign rsp_hs    = rsp_ch.valid && rsp_ch.ready;
   assign pop_entry = rsp_hs && !show_pre;
   assign can_push  = (count_ff != CNT_W'(QUEUE_DEPTH)) || pop_entry;

   // Head entry drives the result channel.
   assign rsp_ch.valid          = count_ff != '0;
   assign rsp_ch.action         = show_pre ? ACT_ERASE_PREV : head.action;
   assign rsp_ch.chunk_index    = show_pre ? head.pre_chunk : head.chunk;
   assign rsp_ch.block_index    = show_pre ? head.pre_block : head.block;
   assign rsp_ch.record_version = head.version;
   assign rsp_ch.blocks_counted = head.tally;
   assign rsp_ch.last           = show_pre ? 1'b0 : head.last;

   // Pointer, count and sub-item bookkeeping.
   always_comb begin
      wr_ptr_in = push_valid ? PTR_W'(wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop_entry ? PTR_W'(rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_valid) - CNT_W'(pop_entry);
      sub_in    = sub_ff;
      if (rsp_hs) begin
         sub_in = show_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // A push into a full queue must coincide with a pop.
   assert property (@(posedge clock) disable iff (reset)
      push_valid && count_ff == CNT_W'(QUEUE_DEPTH) |-> pop_entry)
      else $error("result queue overflow");

   // The second half of a split entry is only pending on a split head.
   assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> count_ff != '0 && head.pre_valid)
      else $error("sub-item pending without a split head entry");

endmodule

[rtl/flash_log_record_placement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash log record placement
// Places versioned records in a circular log of chunks over erase blocks:
// scans the area, then steers commits through erase, write and verify.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req_ch   in         valid / ready       cmd, op_ok, found_version, chunk_blank
//  rsp_ch   out        valid / ready       action, chunk_index, block_index,
//                                          record_version, blocks_counted, last
//  csr      in         csr_we, no wait     csr_index, csr_wdata
//
// One item per clock while the result queue has room: an item is held in the
// input register, then the step logic writes its results into the result queue.
// A successful commit that frees an old block gives two result items, which
// leave the queue one after the other. The result queue holds two items' results;
// a stall on rsp_ch fills it, then the input register, then drops req ready.
// Reset is synchronous and clears control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module flash_log_record_placement (
   input  logic                          clock,
   input  logic                          reset,
   flr_req_if.sink                       req_ch,
   flr_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [flr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [flr_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import flr_pkg::*;

   logic          req_valid_ff, req_valid_in;
   req_item_type  req_item_ff;
   logic          can_push;
   logic          fire;
   rsp_entry_type entry;

   // The held item is processed when the queue has room for its results.
   assign fire         = req_valid_ff && can_push;
   assign req_ch.ready = !req_valid_ff || fire;
   assign req_valid_in = req_ch.ready ? req_ch.valid : req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_item_ff.cmd           <= req_ch.cmd;
         req_item_ff.op_ok         <= req_ch.op_ok;
         req_item_ff.found_version <= req_ch.found_version;
         req_item_ff.chunk_blank   <= req_ch.chunk_blank;
      end
   end

   flr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (fire),
      .item       (req_item_ff),
      .entry_o    (entry)
   );

   flr_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fire),
      .push_entry (entry),
      .can_push   (can_push),
      .rsp_ch     (rsp_ch)
   );

endmodule
